>>> hw/rtl/xfa_pkg.sv
package xfa_pkg;

    // Frame geometry and the parity skip rule.
    localparam int PAYLOAD_BYTES = 160;
    localparam int HISTORY_DEPTH = 16;   // A power of two: the slot is the low bits of seq.
    localparam int SKIP_PERIOD   = 20;

    // Field widths.
    localparam int SEQ_W     = 32;
    localparam int IDX_W     = 8;
    localparam int DAT_W     = 8;
    localparam int DIST_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam int HIST_W    = $clog2(HISTORY_DEPTH);
    localparam int MEM_DEPTH = HISTORY_DEPTH * PAYLOAD_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int RES_W     = $clog2(SKIP_PERIOD + 1);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_DIST_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIST_B = CFG_IDX_W'(1);
    localparam logic [DIST_W-1:0]    DIST_A_RST = DIST_W'(1);
    localparam logic [DIST_W-1:0]    DIST_B_RST = DIST_W'(2);

    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DAT_W-1:0]  t_dat;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [HIST_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [RES_W-1:0]  t_res;

    typedef logic [255:0][RES_W-1:0]            t_byte_tab;
    typedef logic [(1 << RES_W)-1:0][RES_W-1:0] t_shift_tab;

    // Residue of each byte value modulo the skip period.
    function automatic t_byte_tab f_byte_mod_tab();
        t_byte_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = RES_W'(i % SKIP_PERIOD);
        end
        return tab;
    endfunction

    // Residue of (r * 256) modulo the skip period, for every residue r.
    function automatic t_shift_tab f_shift_mod_tab();
        t_shift_tab tab;
        for (int i = 0; i < (1 << RES_W); i++) begin
            tab[i] = RES_W'((i * 256) % SKIP_PERIOD);
        end
        return tab;
    endfunction

    localparam t_byte_tab  BYTE_MOD  = f_byte_mod_tab();
    localparam t_shift_tab SHIFT_MOD = f_shift_mod_tab();

    // One byte step of the running residue: (r * 256 + b) mod SKIP_PERIOD.
    function automatic t_res f_res_step(t_res r, logic [7:0] b);
        logic [RES_W:0] t;
        t = {1'b0, SHIFT_MOD[r]} + {1'b0, BYTE_MOD[b]};
        if (t >= (RES_W + 1)'(SKIP_PERIOD)) begin
            t = t - (RES_W + 1)'(SKIP_PERIOD);
        end
        return t_res'(t);
    endfunction

    // Stage load enables and the input accept strobe.
    typedef struct packed {
        logic acc;
        logic ld1;
        logic ld2;
        logic ld3;
    } t_ctl;

    // Item leaving the address stage.
    typedef struct packed {
        t_seq  seq;
        t_idx  idx;
        t_dat  dat;
        logic  rng;
        logic  ok;
        logic  last;
        t_addr wa;
        t_addr ra;
        t_addr rb;
    } t_s2;

    // Item leaving the history stage.
    typedef struct packed {
        t_seq seq;
        t_idx idx;
        t_dat dat;
        logic ok;
        logic last;
        logic byp_a;
        logic byp_b;
        t_dat rd_a;
        t_dat rd_b;
    } t_s3;

endpackage

>>> hw/rtl/xfa_front.sv
module xfa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xfa_pkg::t_ctl i_ctl,
    input  xfa_pkg::t_seq i_seq,
    input  xfa_pkg::t_idx i_byte_index,
    input  xfa_pkg::t_dat i_data_byte,
    input  xfa_pkg::t_dist i_dist_a,
    input  xfa_pkg::t_dist i_dist_b,
    output logic          o_v1,
    output logic          o_v2,
    output xfa_pkg::t_s2  o_s2
);
    import xfa_pkg::*;

    // Stage 1: range checks, minimum sequence, upper half of the skip residue.
    logic r_v1;
    t_seq r_s1_seq;
    t_idx r_s1_idx;
    t_dat r_s1_dat;
    t_res r_s1_res;
    logic r_s1_rng;
    logic r_s1_last;
    logic r_s1_ge;

    t_res n_s1_res;
    logic n_s1_rng;
    logic n_s1_last;
    logic n_s1_ge;

    // Stage 2: rest of the residue and the three history addresses.
    logic r_v2;
    t_s2  r_s2;
    t_s2  n_s2;
    t_res w_res;
    t_slot w_cur;
    t_slot w_sa;
    t_slot w_sb;

    always_comb begin
        n_s1_res  = f_res_step(f_res_step('0, i_seq[31:24]), i_seq[23:16]);
        n_s1_rng  = 32'(i_byte_index) < 32'(PAYLOAD_BYTES);
        n_s1_last = 32'(i_byte_index) == 32'(PAYLOAD_BYTES - 1);
        n_s1_ge   = (i_seq[SEQ_W-1:DIST_W] != '0) || (i_seq[DIST_W-1:0] >= i_dist_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_ctl.ld1) begin
            r_v1 <= i_ctl.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_s1_seq  <= i_seq;
            r_s1_idx  <= i_byte_index;
            r_s1_dat  <= i_data_byte;
            r_s1_res  <= n_s1_res;
            r_s1_rng  <= n_s1_rng;
            r_s1_last <= n_s1_rng && n_s1_last;
            r_s1_ge   <= n_s1_ge;
        end
    end

    always_comb begin
        w_res = f_res_step(f_res_step(r_s1_res, r_s1_seq[15:8]), r_s1_seq[7:0]);
        w_cur = r_s1_seq[HIST_W-1:0];
        w_sa  = t_slot'(w_cur - t_slot'(i_dist_a));
        w_sb  = t_slot'(w_cur - t_slot'(i_dist_b));

        n_s2.seq  = r_s1_seq;
        n_s2.idx  = r_s1_idx;
        n_s2.dat  = r_s1_dat;
        n_s2.rng  = r_s1_rng;
        n_s2.ok   = r_s1_rng && r_s1_ge && (w_res != '0);
        n_s2.last = r_s1_last;
        n_s2.wa   = t_addr'(t_addr'(w_cur) * t_addr'(PAYLOAD_BYTES) + t_addr'(r_s1_idx));
        n_s2.ra   = t_addr'(t_addr'(w_sa) * t_addr'(PAYLOAD_BYTES) + t_addr'(r_s1_idx));
        n_s2.rb   = t_addr'(t_addr'(w_sb) * t_addr'(PAYLOAD_BYTES) + t_addr'(r_s1_idx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_ctl.ld2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    assign o_v1 = r_v1;
    assign o_v2 = r_v2;
    assign o_s2 = r_s2;

endmodule

>>> hw/rtl/xfa_hist.sv
module xfa_hist (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_ld3,
    input  logic         i_v2,
    input  xfa_pkg::t_s2 i_s2,
    output logic         o_busy,
    output logic         o_v3,
    output xfa_pkg::t_s3 o_s3
);
    import xfa_pkg::*;

    // History ring: HISTORY_DEPTH frames of PAYLOAD_BYTES bytes each.
    t_dat  mem [MEM_DEPTH];

    logic  r_clearing;
    t_addr r_clr_addr;

    logic  r_v3;
    t_seq  r_seq;
    t_idx  r_idx;
    t_dat  r_dat;
    logic  r_ok;
    logic  r_last;
    logic  r_byp_a;
    logic  r_byp_b;
    t_dat  r_rd_a;
    t_dat  r_rd_b;

    logic  w_take;
    logic  w_we;

    assign w_take = i_v2 && i_ld3;
    assign w_we   = w_take && i_s2.rng;

    // After reset every entry is written with zero, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= t_addr'(r_clr_addr + 1'b1);
            if (r_clr_addr == t_addr'(MEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (w_we) begin
            mem[i_s2.wa] <= i_s2.dat;
        end
    end

    // Reads see the old contents; the item's own byte comes in by bypass.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd_a <= mem[i_s2.ra];
            r_rd_b <= mem[i_s2.rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_ld3) begin
            r_v3 <= i_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_seq   <= i_s2.seq;
            r_idx   <= i_s2.idx;
            r_dat   <= i_s2.dat;
            r_ok    <= i_s2.ok;
            r_last  <= i_s2.last;
            r_byp_a <= w_we && (i_s2.ra == i_s2.wa);
            r_byp_b <= w_we && (i_s2.rb == i_s2.wa);
        end
    end

    always_comb begin
        o_s3.seq   = r_seq;
        o_s3.idx   = r_idx;
        o_s3.dat   = r_dat;
        o_s3.ok    = r_ok;
        o_s3.last  = r_last;
        o_s3.byp_a = r_byp_a;
        o_s3.byp_b = r_byp_b;
        o_s3.rd_a  = r_rd_a;
        o_s3.rd_b  = r_rd_b;
    end

    assign o_busy = r_clearing;
    assign o_v3   = r_v3;

    // No item may reach the history stage while the clearing sweep runs.
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_v2)
        else $error("item in flight during history clear");

endmodule

>>> hw/rtl/xor_fec_frame_appender_top.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_seq, i_byte_index, i_data_byte
// output    out        o_valid / i_stall         o_seq_out, o_index_out, o_payload_out,
//                                                o_parity_byte, o_parity_valid, o_last_byte
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is taken per clock while o_stall is low; its result passes through stage 1,
// stage 2, the history stage and the output register, and leaves while i_stall is low.
// The pace is set by the single write port and two read ports of the history memory;
// every item uses the read ports once and every in-range item uses the write port once.
// After reset the history memory is swept to zero, one byte per cycle, across all
// HISTORY_DEPTH * PAYLOAD_BYTES (2560) bytes; o_stall stays high during the sweep.
// A stall on the output holds each full stage whose later stages are all full; the others keep filling.
module xor_fec_frame_appender_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  xfa_pkg::t_seq                      i_seq,
    input  xfa_pkg::t_idx                      i_byte_index,
    input  xfa_pkg::t_dat                      i_data_byte,

    output logic                               o_valid,
    input  logic                               i_stall,
    output xfa_pkg::t_seq                      o_seq_out,
    output xfa_pkg::t_idx                      o_index_out,
    output xfa_pkg::t_dat                      o_payload_out,
    output xfa_pkg::t_dat                      o_parity_byte,
    output logic                               o_parity_valid,
    output logic                               o_last_byte,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [xfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  xfa_pkg::t_dist                     i_cfg_data
);
    import xfa_pkg::*;

    // Configuration registers.
    t_dist r_dist_a;
    t_dist r_dist_b;

    // Pipeline control. Each stage loads when it is empty or when the stage
    // after it is loading, so bubbles close up under a stall.
    t_ctl  w_ctl;
    logic  w_ld4;
    logic  w_v1;
    logic  w_v2;
    logic  w_v3;
    logic  w_busy;
    t_s2   w_s2;
    t_s3   w_s3;

    // Output register.
    logic  r_out_valid;
    t_seq  r_out_seq;
    t_idx  r_out_idx;
    t_dat  r_out_dat;
    t_dat  r_out_parity;
    logic  r_out_pvalid;
    logic  r_out_last;

    t_dat  w_byte_a;
    t_dat  w_byte_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_a <= DIST_A_RST;
            r_dist_b <= DIST_B_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DIST_A: r_dist_a <= i_cfg_data;
                REG_DIST_B: r_dist_b <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_ld4     = !r_out_valid || !i_stall;
        w_ctl.ld3 = !w_v3 || w_ld4;
        w_ctl.ld2 = !w_v2 || w_ctl.ld3;
        w_ctl.ld1 = !w_v1 || w_ctl.ld2;
        o_stall   = !w_ctl.ld1 || w_busy;
        w_ctl.acc = i_valid && !o_stall;
    end

    xfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_seq        (i_seq),
        .i_byte_index (i_byte_index),
        .i_data_byte  (i_data_byte),
        .i_dist_a     (r_dist_a),
        .i_dist_b     (r_dist_b),
        .o_v1         (w_v1),
        .o_v2         (w_v2),
        .o_s2         (w_s2)
    );

    xfa_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld3   (w_ctl.ld3),
        .i_v2    (w_v2),
        .i_s2    (w_s2),
        .o_busy  (w_busy),
        .o_v3    (w_v3),
        .o_s3    (w_s3)
    );

    // A distance that lands on the current frame reads the byte this item writes.
    assign w_byte_a = w_s3.byp_a ? w_s3.dat : w_s3.rd_a;
    assign w_byte_b = w_s3.byp_b ? w_s3.dat : w_s3.rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld4) begin
            r_out_valid <= w_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld4 && w_v3) begin
            r_out_seq    <= w_s3.seq;
            r_out_idx    <= w_s3.idx;
            r_out_dat    <= w_s3.dat;
            r_out_parity <= w_s3.ok ? (w_byte_a ^ w_byte_b) : '0;
            r_out_pvalid <= w_s3.ok;
            r_out_last   <= w_s3.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_seq_out      = r_out_seq;
    assign o_index_out    = r_out_idx;
    assign o_payload_out  = r_out_dat;
    assign o_parity_byte  = r_out_parity;
    assign o_parity_valid = r_out_pvalid;
    assign o_last_byte    = r_out_last;

    // Parity without the valid flag is always zero.
    a_parity_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_parity_valid) |-> (o_parity_byte == '0))
        else $error("parity byte nonzero while parity not valid");

    // The last-byte flag only marks the final position of the payload.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> (32'(o_index_out) == 32'(PAYLOAD_BYTES - 1)))
        else $error("last byte flagged at wrong position");

    // Valid parity is only produced for bytes inside the payload.
    a_parity_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parity_valid) |-> (32'(o_index_out) < 32'(PAYLOAD_BYTES)))
        else $error("parity valid on out-of-range byte");

endmodule

>>> sim/tb_xor_fec_frame_appender_top.sv
`default_nettype none

module tb_xor_fec_frame_appender_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xfa_pkg::*;

    // One result as it leaves the block. Every accepted item produces exactly one.
    typedef struct packed {
        t_seq seq;
        t_idx idx;
        t_dat dat;
        t_dat par;
        logic pvld;
        logic last;
    } t_fec_res;

    // One row of the directed table. When typed is set, the parity and last-byte fields of
    // the expected result are taken from the row; otherwise the predictor supplies them.
    typedef struct packed {
        t_dist da;
        t_dist db;
        t_seq  seq;
        t_idx  idx;
        t_dat  dat;
        bit    typed;
        t_dat  par;
        bit    pvld;
        bit    last;
    } t_dir_row;

    localparam int N_DIR     = 19;
    localparam int LONG_HOLD = 300;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    t_seq          i_seq;
    t_idx          i_byte_index;
    t_dat          i_data_byte;
    logic          o_valid;
    logic          i_stall;
    t_seq          o_seq_out;
    t_idx          o_index_out;
    t_dat          o_payload_out;
    t_dat          o_parity_byte;
    logic          o_parity_valid;
    logic          o_last_byte;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_dist         i_cfg_data;

    xor_fec_frame_appender_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_seq          (i_seq),
        .i_byte_index   (i_byte_index),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_seq_out      (o_seq_out),
        .o_index_out    (o_index_out),
        .o_payload_out  (o_payload_out),
        .o_parity_byte  (o_parity_byte),
        .o_parity_valid (o_parity_valid),
        .o_last_byte    (o_last_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // The predictor's own copy of the block's state: the history ring of recent
    // frames and the two protection distances.
    t_dat  frame_hist [HISTORY_DEPTH][PAYLOAD_BYTES];
    t_dist dist_a = DIST_A_RST;
    t_dist dist_b = DIST_B_RST;

    // Results still owed by the block, oldest first.
    t_fec_res pending_fec [$];

    int  n_err       = 0;
    int  n_items     = 0;
    int  n_results   = 0;
    int  n_pvld      = 0;
    int  n_oor       = 0;
    int  n_settings  = 1;
    bit  tx_steady   = 1'b0;
    bit  hold_req    = 1'b0;

    // Directed items. The first block runs under the reset distances and walks
    // through the skip rule, the minimum sequence, the last byte, indexes past the
    // payload and sequence numbers at both ends of the 32-bit range. The later
    // blocks use zero distances (both reading the slot just written), a distance
    // that reaches back before sequence zero, and both distances at their maximum.
    t_dir_row dir_tab [N_DIR] = '{
        '{4'd1,  4'd2,  32'h0000_0000, 8'd0,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h0000_0001, 8'd159, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1},
        '{4'd1,  4'd2,  32'h0000_0002, 8'd159, 8'h3C, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h0000_0003, 8'd159, 8'h5A, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h0000_0014, 8'd159, 8'h11, 1'b1, 8'h00, 1'b0, 1'b1},
        '{4'd1,  4'd2,  32'h0000_0015, 8'd159, 8'h22, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h0000_0003, 8'd160, 8'h77, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h0000_0005, 8'd255, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'hFFFF_FFFF, 8'd0,   8'h80, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h0000_0001, 8'd0,   8'h7F, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'hFFFF_FFF0, 8'd1,   8'h01, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'hAAAA_AAAA, 8'h55,  8'hAA, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd1,  4'd2,  32'h5555_5555, 8'hAA,  8'h55, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd0,  4'd0,  32'h0000_0000, 8'd7,   8'hC3, 1'b1, 8'h00, 1'b0, 1'b0},
        '{4'd0,  4'd0,  32'h0000_0001, 8'd7,   8'hC3, 1'b1, 8'h00, 1'b1, 1'b0},
        '{4'd15, 4'd0,  32'h0000_0003, 8'd7,   8'h9E, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd0,  4'd15, 32'h0000_0010, 8'd7,   8'h9E, 1'b0, 8'h00, 1'b0, 1'b0},
        '{4'd15, 4'd15, 32'h0000_000F, 8'd159, 8'hE7, 1'b1, 8'h00, 1'b1, 1'b1},
        '{4'd15, 4'd15, 32'h0000_0028, 8'd159, 8'h18, 1'b1, 8'h00, 1'b0, 1'b1}
    };

    // Works out the result of one byte and updates the history, store first and
    // lookup second, so a distance of zero reads back the byte just written.
    function automatic t_fec_res predict_fec(t_seq seq, t_idx idx, t_dat dat);
        t_fec_res r;
        t_slot    s_cur;
        t_slot    s_a;
        t_slot    s_b;
        logic     in_rng;
        in_rng = int'(idx) < PAYLOAD_BYTES;
        r.seq  = seq;
        r.idx  = idx;
        r.dat  = dat;
        r.par  = '0;
        r.pvld = in_rng && (seq >= t_seq'(dist_b))
                 && ((seq % t_seq'(SKIP_PERIOD)) != '0);
        r.last = in_rng && (int'(idx) == PAYLOAD_BYTES - 1);
        if (in_rng) begin
            s_cur = t_slot'(seq % t_seq'(HISTORY_DEPTH));
            frame_hist[s_cur][idx] = dat;
            if (r.pvld) begin
                // The subtraction wraps at 32 bits before the slot is taken.
                s_a = t_slot'((seq - t_seq'(dist_a)) % t_seq'(HISTORY_DEPTH));
                s_b = t_slot'((seq - t_seq'(dist_b)) % t_seq'(HISTORY_DEPTH));
                r.par = frame_hist[s_a][idx] ^ frame_hist[s_b][idx];
            end
        end
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        $display("%0t ERROR %s: expected %h, actual %h", $time, name, exp_v, got_v);
        n_err++;
    endfunction

    // Compares one accepted result with the oldest expectation, field by field.
    function automatic void check_result();
        t_fec_res e;
        if (pending_fec.size() == 0) begin
            $display("%0t ERROR result with nothing pending: expected none, actual seq %h idx %h",
                     $time, o_seq_out, o_index_out);
            n_err++;
            return;
        end
        e = pending_fec.pop_front();
        n_results++;
        if (o_parity_valid === 1'b1) n_pvld++;
        if (o_seq_out !== e.seq)           report_field("seq_out", e.seq, o_seq_out);
        if (o_index_out !== e.idx)         report_field("index_out", e.idx, o_index_out);
        if (o_payload_out !== e.dat)       report_field("payload_out", e.dat, o_payload_out);
        if (o_parity_byte !== e.par)       report_field("parity_byte", e.par, o_parity_byte);
        if (o_parity_valid !== e.pvld)     report_field("parity_valid", e.pvld, o_parity_valid);
        if (o_last_byte !== e.last)        report_field("last_byte", e.last, o_last_byte);
    endfunction

    // Offers one item after a random gap and returns at the edge that accepts it.
    // The payload is held while the block stalls.
    task automatic offer_item(t_seq s, t_idx ix, t_dat d);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_seq        <= s;
        i_byte_index <= ix;
        i_data_byte  <= d;
        do @(posedge i_clk); while (o_stall);
        n_items++;
        if (int'(ix) >= PAYLOAD_BYTES) n_oor++;
    endtask

    task automatic send_byte(t_seq s, t_idx ix, t_dat d);
        offer_item(s, ix, d);
        pending_fec.push_back(predict_fec(s, ix, d));
    endtask

    // Drops valid after the last accepted item so it is not taken twice.
    task automatic sender_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_fec.size() != 0) @(posedge i_clk);
    endtask

    // Writes both distances back to back; valid stays high between the two writes.
    task automatic write_dists(t_dist a, t_dist b);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_DIST_A;
        i_cfg_data  <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        dist_a = a;
        i_cfg_index <= REG_DIST_B;
        i_cfg_data  <= b;
        do @(posedge i_clk); while (!o_cfg_ready);
        dist_b = b;
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // One stretch of traffic under the current distances. Most of it is runs of
    // consecutive frames that fill a small set of byte positions, so the parity
    // lookups land on bytes written a few frames earlier. The rest is noise:
    // indexes past the payload, stray sequence numbers, and sequences that jump
    // back or skip ahead.
    task automatic run_phase(int n_want);
        t_seq seq;
        t_idx pool [4];
        int   n_pool;
        int   stop_at;
        int   pick;
        case ($urandom_range(0, 3))
            0:       seq = t_seq'($urandom_range(0, 3));
            1:       seq = 32'hFFFF_FFFF - t_seq'($urandom_range(0, 30));
            default: seq = t_seq'($urandom());
        endcase
        n_pool = $urandom_range(1, 4);
        foreach (pool[k]) pool[k] = t_idx'($urandom_range(0, PAYLOAD_BYTES - 1));
        if ($urandom_range(0, 1) == 1) pool[n_pool - 1] = t_idx'(PAYLOAD_BYTES - 1);
        if ($urandom_range(0, 3) == 0) pool[0] = '0;
        stop_at = n_items + n_want;
        while (n_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_byte(t_seq'($urandom()), t_idx'($urandom_range(PAYLOAD_BYTES, 255)),
                          t_dat'($urandom_range(0, 255)));
            end else if (pick < 10) begin
                send_byte(t_seq'($urandom()), t_idx'($urandom_range(0, PAYLOAD_BYTES - 1)),
                          t_dat'($urandom_range(0, 255)));
            end else if (pick < 13) begin
                seq = seq - t_seq'($urandom_range(1, 20));
            end else begin
                for (int k = 0; k < n_pool; k++) begin
                    send_byte(seq, pool[k], t_dat'($urandom_range(0, 255)));
                end
                seq = seq + t_seq'(($urandom_range(0, 9) == 0) ? 2 : 1);
            end
        end
    endtask

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiving side. It checks every accepted result and then decides the stall
    // for the next cycle: runs with no stall alternate with random gaps, and on
    // request it holds off for a long stretch, counted here, so the block fills
    // and pushes back on its input.
    initial begin
        int gap_left;
        int run_left;
        int hold_left;
        gap_left  = 0;
        run_left  = 0;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) check_result();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                i_stall <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_stall <= 1'b1;
            end else begin
                run_left = $urandom_range(0, 30);
                gap_left = pick_gap();
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin
        t_fec_res exp_r;
        t_dist    pa [6];
        t_dist    pb [6];
        t_dist    na;
        t_dist    nb;
        pa = '{4'd15, 4'd0, 4'd1,  4'd15, 4'd3, 4'd0};
        pb = '{4'd15, 4'd0, 4'd15, 4'd0,  4'd7, 4'd15};
        foreach (frame_hist[s, b]) frame_hist[s][b] = '0;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_seq        <= '0;
        i_byte_index <= '0;
        i_data_byte  <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_DIST_A;
        i_cfg_data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. A change of distances in the table drains the block and
        // rewrites both registers before the row is sent. The history sweep that
        // follows reset simply shows up as a stalled input for the first item.
        foreach (dir_tab[i]) begin
            if (dir_tab[i].da != dist_a || dir_tab[i].db != dist_b) begin
                sender_idle();
                wait_drained();
                write_dists(dir_tab[i].da, dir_tab[i].db);
            end
            offer_item(dir_tab[i].seq, dir_tab[i].idx, dir_tab[i].dat);
            exp_r = predict_fec(dir_tab[i].seq, dir_tab[i].idx, dir_tab[i].dat);
            if (dir_tab[i].typed) begin
                exp_r.par  = dir_tab[i].par;
                exp_r.pvld = dir_tab[i].pvld;
                exp_r.last = dir_tab[i].last;
            end
            pending_fec.push_back(exp_r);
        end

        // Random phases: fixed settings at the extremes first, then random ones.
        // Every phase starts from an idle block with freshly written distances.
        for (int p = 0; p < 9; p++) begin
            if (p < 6) begin
                na = pa[p];
                nb = pb[p];
            end else begin
                na = t_dist'($urandom_range(0, 15));
                nb = t_dist'($urandom_range(0, 15));
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            sender_idle();
            wait_drained();
            write_dists(na, nb);
            // The output holds off for a long stretch while items keep coming.
            if (p == 1) hold_req = 1'b1;
            run_phase(90);
            // Here the sender stops until every owed result has come back.
            if (p == 3) begin
                sender_idle();
                wait_drained();
            end
            run_phase(90);
        end

        sender_idle();
        wait_drained();
        // A few more cycles to catch any result the block sends without cause.
        repeat (20) @(posedge i_clk);

        $display("Covered %0d items under %0d distance settings, with a long output hold",
                 n_items, n_settings);
        $display("and a full drain; %0d results carried parity, %0d items were past the payload.",
                 n_pvld, n_oor);
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Safety net well beyond the slowest legal run, the history sweep included.
    initial begin
        #8_000_000;
        $display("Timeout with %0d results still owed.", pending_fec.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> xor_fec_frame_appender_top.f
hw/rtl/xfa_pkg.sv
hw/rtl/xfa_front.sv
hw/rtl/xfa_hist.sv
hw/rtl/xor_fec_frame_appender_top.sv
sim/tb_xor_fec_frame_appender_top.sv
